[hw/rtl/tcf_pkg.sv]
// Shared types, register codes, CORDIC angle table and saturation helper
// for the tilt complementary filter. No dependencies.
package tcf_pkg;

    localparam int IN_W      = 16;
    localparam int ANGLE_W   = 26;   // CORDIC angle accumulator, Q10.16 degrees
    localparam int CORDIC_W  = 33;   // CORDIC x/y datapath
    localparam int MUL_B_W   = 18;
    localparam int SUM_W     = CORDIC_W + MUL_B_W;
    localparam int IDX_W     = 5;
    localparam int ATAN_TABLE_LEN = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 17;

    localparam logic signed [ANGLE_W-1:0] DEG90_Q16 = ANGLE_W'(5898240);
    localparam logic [16:0] ALPHA_ONE = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_WEIGHT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_LOW  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_HIGH = 8'd3;

    typedef struct packed {
        logic signed [IN_W-1:0] acc_x;
        logic signed [IN_W-1:0] acc_y;
        logic signed [IN_W-1:0] acc_z;
        logic signed [IN_W-1:0] gyro_x;
        logic signed [IN_W-1:0] gyro_y;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pitch_out;
        logic signed [31:0] roll_out;
        logic               accel_applied;
    } out_t;

    typedef struct packed {
        logic                   start;
        logic signed [IN_W-1:0] num;
        logic signed [IN_W-1:0] den;
    } cordic_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GYRO_P,
        ST_GYRO_R,
        ST_GYRO_WB,
        ST_CORDIC_WAIT,
        ST_BLEND_MUL1,
        ST_BLEND_MUL2,
        ST_BLEND_WB,
        ST_FINISH
    } tcf_state_t;

    // atan(2^-i) in Q10.16 degrees, rounded to nearest
    function automatic logic signed [ANGLE_W-1:0] atan_lookup(input logic [IDX_W-1:0] i);
        logic signed [ANGLE_W-1:0] v;
        unique case (i)
            5'd0:  v = ANGLE_W'(2949120);
            5'd1:  v = ANGLE_W'(1740967);
            5'd2:  v = ANGLE_W'(919879);
            5'd3:  v = ANGLE_W'(466945);
            5'd4:  v = ANGLE_W'(234379);
            5'd5:  v = ANGLE_W'(117304);
            5'd6:  v = ANGLE_W'(58666);
            5'd7:  v = ANGLE_W'(29335);
            5'd8:  v = ANGLE_W'(14668);
            5'd9:  v = ANGLE_W'(7334);
            5'd10: v = ANGLE_W'(3667);
            5'd11: v = ANGLE_W'(1833);
            5'd12: v = ANGLE_W'(917);
            5'd13: v = ANGLE_W'(458);
            5'd14: v = ANGLE_W'(229);
            5'd15: v = ANGLE_W'(115);
            5'd16: v = ANGLE_W'(57);
            5'd17: v = ANGLE_W'(29);
            5'd18: v = ANGLE_W'(14);
            5'd19: v = ANGLE_W'(7);
            5'd20: v = ANGLE_W'(4);
            5'd21: v = ANGLE_W'(2);
            5'd22: v = ANGLE_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [31:0]      r;
        hi = $signed({{(SUM_W-32){1'b0}}, 32'h7fff_ffff});
        lo = $signed({{(SUM_W-32){1'b1}}, 32'h8000_0000});
        if (v > hi) begin
            r = 32'sh7fff_ffff;
        end else if (v < lo) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/tcf_cordic.sv]
// Iterative vectoring CORDIC: atan2(num, den) in Q10.16 degrees, one step per cycle.
// Depends on tcf_pkg (request type, widths, angle table).
module tcf_cordic
    import tcf_pkg::*;
#(
    parameter int ITERATIONS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cordic_req_t               req,
    output logic                      done,
    output logic signed [ANGLE_W-1:0] angle
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ITERATIONS - 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [IDX_W-1:0]           cnt_reg, cnt_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [ANGLE_W-1:0]  z_reg, z_next;

    logic signed [CORDIC_W-1:0] x_load, y_load, x_sh, y_sh;
    logic                       both_zero;

    always_comb begin
        x_load    = $signed({{(CORDIC_W-IN_W-14){req.den[IN_W-1]}}, req.den, 14'b0});
        y_load    = $signed({{(CORDIC_W-IN_W-14){req.num[IN_W-1]}}, req.num, 14'b0});
        both_zero = (req.num == '0) && (req.den == '0);
        x_sh      = x_reg >>> cnt_reg;
        y_sh      = y_reg >>> cnt_reg;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;

        if (req.start) begin
            cnt_next = '0;
            if (both_zero) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                z_next    = '0;
            end else begin
                busy_next = 1'b1;
                // pre-rotate into the right half plane
                priority if (x_load < 0 && y_load >= 0) begin
                    x_next = y_load;
                    y_next = -x_load;
                    z_next = DEG90_Q16;
                end else if (x_load < 0) begin
                    x_next = -y_load;
                    y_next = x_load;
                    z_next = -DEG90_Q16;
                end else begin
                    x_next = x_load;
                    y_next = y_load;
                    z_next = '0;
                end
            end
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + atan_lookup(cnt_reg);
            end else begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - atan_lookup(cnt_reg);
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_IDX) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign angle = z_reg;

endmodule

[hw/rtl/tilt_complementary_filter_unit.sv]
// Tilt complementary filter top level: gyro integration, accel window check,
// shared multiplier blend and sequencer. Depends on tcf_pkg and tcf_cordic.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_data  (in_t)
//  m_        out        m_valid / m_ready    m_data  (out_t)
//  cfg_      in         cfg_write            cfg_index, cfg_data
//
// An item without accelerometer correction goes from the gyro states straight to
// the finish state. With correction, the single-step CORDIC (at most 24 iterations)
// runs once for pitch and once for roll, and the one multiplier is shared by gyro
// and blend products.
// Synchronous active-low reset clears angles to zero and loads register defaults.
// A stalled result holds in the output register; a new item is taken meanwhile.
module tilt_complementary_filter_unit
    import tcf_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ITERS = (CORDIC_ITERATIONS > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN
                                                                 : CORDIC_ITERATIONS;

    tcf_state_t state_reg, state_next;

    logic [16:0] alpha_reg;
    logic [15:0] gain_reg;
    logic [16:0] mag_low_reg;
    logic [16:0] mag_high_reg;

    in_t                        in_reg;
    logic signed [31:0]         pitch_reg, pitch_next;
    logic signed [31:0]         roll_reg, roll_next;
    logic                       apply_reg, apply_next;
    logic                       phase_roll_reg, phase_roll_next;
    logic signed [SUM_W-1:0]    prod_reg;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    out_t                       out_reg;
    logic                       m_valid_reg, m_valid_next;

    logic signed [CORDIC_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [SUM_W-1:0]    mul_p;
    logic signed [SUM_W-1:0]    wb_sum;
    logic signed [31:0]         blend_res;
    logic signed [31:0]         cur_angle;
    logic [16:0]                alpha_cap, alpha_inv;
    logic [16:0]                abs_x, abs_y, abs_z;
    logic [17:0]                mag;
    logic                       apply_now;
    logic                       s_transfer, m_transfer, load_out;

    cordic_req_t                cordic_req;
    logic                       cordic_done;
    logic signed [ANGLE_W-1:0]  cordic_angle;

    tcf_cordic #(
        .ITERATIONS(ITERS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cordic_req),
        .done    (cordic_done),
        .angle   (cordic_angle)
    );

    assign s_transfer = s_valid && s_ready;
    assign m_transfer = m_valid_reg && m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:        if (s_transfer) state_next = ST_GYRO_P;
            ST_GYRO_P:      state_next = ST_GYRO_R;
            ST_GYRO_R:      state_next = ST_GYRO_WB;
            ST_GYRO_WB:     state_next = apply_now ? ST_CORDIC_WAIT : ST_FINISH;
            ST_CORDIC_WAIT: if (cordic_done) state_next = ST_BLEND_MUL1;
            ST_BLEND_MUL1:  state_next = ST_BLEND_MUL2;
            ST_BLEND_MUL2:  state_next = ST_BLEND_WB;
            ST_BLEND_WB:    state_next = phase_roll_reg ? ST_FINISH : ST_CORDIC_WAIT;
            ST_FINISH:      if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready          = (state_reg == ST_IDLE);
        load_out         = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
        cordic_req.start = ((state_reg == ST_GYRO_WB) && apply_now) ||
                           ((state_reg == ST_BLEND_WB) && !phase_roll_reg);
        cordic_req.num   = (state_reg == ST_GYRO_WB) ? in_reg.acc_y : in_reg.acc_x;
        cordic_req.den   = in_reg.acc_z;
    end

    // datapath
    always_comb begin
        abs_x     = in_reg.acc_x[IN_W-1] ? 17'(-$signed({in_reg.acc_x[IN_W-1], in_reg.acc_x}))
                                         : {1'b0, in_reg.acc_x};
        abs_y     = in_reg.acc_y[IN_W-1] ? 17'(-$signed({in_reg.acc_y[IN_W-1], in_reg.acc_y}))
                                         : {1'b0, in_reg.acc_y};
        abs_z     = in_reg.acc_z[IN_W-1] ? 17'(-$signed({in_reg.acc_z[IN_W-1], in_reg.acc_z}))
                                         : {1'b0, in_reg.acc_z};
        mag       = {1'b0, abs_x} + {1'b0, abs_y} + {1'b0, abs_z};
        apply_now = (mag > {1'b0, mag_low_reg}) && (mag < {1'b0, mag_high_reg});

        alpha_cap = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
        alpha_inv = ALPHA_ONE - alpha_cap;
        cur_angle = phase_roll_reg ? roll_reg : pitch_reg;

        unique case (state_reg)
            ST_GYRO_P: begin
                mul_a = CORDIC_W'(in_reg.gyro_x);
                mul_b = $signed({2'b00, gain_reg});
            end
            ST_GYRO_R: begin
                mul_a = CORDIC_W'(in_reg.gyro_y);
                mul_b = $signed({2'b00, gain_reg});
            end
            ST_BLEND_MUL1: begin
                mul_a = CORDIC_W'(cur_angle);
                mul_b = $signed({1'b0, alpha_inv});
            end
            ST_BLEND_MUL2: begin
                mul_a = CORDIC_W'(cordic_angle);
                mul_b = $signed({1'b0, alpha_cap});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;

        wb_sum    = sum_reg + prod_reg;
        blend_res = sat32(wb_sum >>> 16);

        pitch_next      = pitch_reg;
        roll_next       = roll_reg;
        apply_next      = apply_reg;
        phase_roll_next = phase_roll_reg;
        sum_next        = sum_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_transfer) phase_roll_next = 1'b0;
            end
            ST_GYRO_R:     pitch_next = sat32(SUM_W'(pitch_reg) + prod_reg);
            ST_GYRO_WB: begin
                roll_next  = sat32(SUM_W'(roll_reg) - prod_reg);
                apply_next = apply_now;
            end
            ST_BLEND_MUL2: sum_next = prod_reg + SUM_W'(32768);
            ST_BLEND_WB: begin
                if (phase_roll_reg) begin
                    roll_next = blend_res;
                end else begin
                    pitch_next      = blend_res;
                    phase_roll_next = 1'b1;
                end
            end
            default: ;
        endcase

        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_transfer) begin
            m_valid_next = 1'b0;
        end
    end

    // control and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            pitch_reg      <= '0;
            roll_reg       <= '0;
            apply_reg      <= 1'b0;
            phase_roll_reg <= 1'b0;
            alpha_reg      <= 17'd6554;
            gain_reg       <= 16'd10;
            mag_low_reg    <= 17'd8192;
            mag_high_reg   <= 17'd32768;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            pitch_reg      <= pitch_next;
            roll_reg       <= roll_next;
            apply_reg      <= apply_next;
            phase_roll_reg <= phase_roll_next;
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_ALPHA_WEIGHT:   alpha_reg    <= cfg_data;
                    REG_GYRO_GAIN:      gain_reg     <= cfg_data[15:0];
                    REG_MAGNITUDE_LOW:  mag_low_reg  <= cfg_data;
                    REG_MAGNITUDE_HIGH: mag_high_reg <= cfg_data;
                    default: ;  // drop writes beyond the register list
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_transfer) in_reg <= s_data;
        prod_reg <= mul_p;
        sum_reg  <= sum_next;
        if (load_out) begin
            out_reg.pitch_out     <= pitch_reg;
            out_reg.roll_out      <= roll_reg;
            out_reg.accel_applied <= apply_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_cordic_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> (state_reg == ST_CORDIC_WAIT))
        else $error("CORDIC finished outside its wait state");

    a_blend_only_applied: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BLEND_MUL1) |-> apply_reg)
        else $error("blend started without accelerometer correction");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish state");

endmodule

[tb/sv/tb_tilt_complementary_filter_unit.sv]
// Self-checking testbench for tilt_complementary_filter_unit: gyro integration,
// accelerometer window and CORDIC blend checked against a local angle predictor.
// Depends on tcf_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_tilt_complementary_filter_unit;
    import tcf_pkg::*;

    localparam int          CORDIC_STEPS = 16;
    localparam longint      QUARTER_TURN = 5898240;   // 90 degrees, Q16.16
    localparam longint      ACC_SCALE    = 16384;
    localparam longint      UNITY_WEIGHT = 65536;
    localparam int          LONG_HOLD    = 400;
    localparam int          STALL_LIMIT  = 3000;
    localparam int          SETTLE       = 8;
    localparam int          DRAIN        = 60;
    localparam int          RAND_PHASES  = 6;
    localparam int          PHASE_ITEMS  = 105;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_RANGE = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_CODE     = 8'd255;

    // atan(2^-i) in Q16.16 degrees
    localparam longint ATAN_DEG_Q16 [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    class angle_scoreboard;
        logic [16:0]        alpha;
        logic [15:0]        gain;
        logic [16:0]        mag_lo;
        logic [16:0]        mag_hi;
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
        out_t               expected_angles[$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        blended;

        function new();
            alpha   = 17'd6554;
            gain    = 16'd10;
            mag_lo  = 17'd8192;
            mag_hi  = 17'd32768;
            pitch   = '0;
            roll    = '0;
            errors  = 0;
            checked = 0;
            blended = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] val);
            case (idx)
                REG_ALPHA_WEIGHT:   alpha  = val;
                REG_GYRO_GAIN:      gain   = val[15:0];
                REG_MAGNITUDE_LOW:  mag_lo = val;
                REG_MAGNITUDE_HIGH: mag_hi = val;
                default: ;
            endcase
        endfunction

        function logic signed [31:0] sat_q16(longint v);
            if (v > 64'sd2147483647) return 32'sh7fff_ffff;
            if (v < -64'sd2147483648) return 32'sh8000_0000;
            return v[31:0];
        endfunction

        // vectoring CORDIC, result in Q16.16 degrees
        function longint accel_angle(longint num, longint den);
            longint x, y, z, nx, ny;
            if (num == 0 && den == 0) return 0;
            x = den * ACC_SCALE;
            y = num * ACC_SCALE;
            z = 0;
            if (x < 0) begin
                if (y >= 0) begin
                    nx = y;
                    ny = -x;
                    z  = QUARTER_TURN;
                end else begin
                    nx = -y;
                    ny = x;
                    z  = -QUARTER_TURN;
                end
                x = nx;
                y = ny;
            end
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                if (y > 0) begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z  = z + ATAN_DEG_Q16[i];
                end else begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z  = z - ATAN_DEG_Q16[i];
                end
                x = nx;
                y = ny;
            end
            return z;
        endfunction

        function logic signed [31:0] blend_toward(logic signed [31:0] angle, longint target,
                                                  longint w);
            longint sum;
            sum = longint'(angle) * (UNITY_WEIGHT - w) + target * w + 32768;
            return sat_q16(sum >>> 16);
        endfunction

        function void note_input(in_t d);
            longint ax, ay, az, gx, gy, g, lo, hi, mag, w;
            out_t   want;
            ax = d.acc_x;
            ay = d.acc_y;
            az = d.acc_z;
            gx = d.gyro_x;
            gy = d.gyro_y;
            g  = gain;
            lo = mag_lo;
            hi = mag_hi;
            w  = alpha;
            pitch = sat_q16(longint'(pitch) + gx * g);
            roll  = sat_q16(longint'(roll) - gy * g);
            mag = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + (az < 0 ? -az : az);
            want.accel_applied = 1'b0;
            if (mag > lo && mag < hi) begin
                if (w > UNITY_WEIGHT) w = UNITY_WEIGHT;
                pitch = blend_toward(pitch, accel_angle(ay, az), w);
                roll  = blend_toward(roll, accel_angle(ax, az), w);
                want.accel_applied = 1'b1;
                blended++;
            end
            want.pitch_out = pitch;
            want.roll_out  = roll;
            expected_angles.push_back(want);
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (expected_angles.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: pitch %0d roll %0d applied %0b",
                         $time, got.pitch_out, got.roll_out, got.accel_applied);
                return;
            end
            want = expected_angles.pop_front();
            checked++;
            if (got.pitch_out !== want.pitch_out) begin
                errors++;
                $display("%0t: pitch_out expected %0d actual %0d",
                         $time, want.pitch_out, got.pitch_out);
            end
            if (got.roll_out !== want.roll_out) begin
                errors++;
                $display("%0t: roll_out expected %0d actual %0d",
                         $time, want.roll_out, got.roll_out);
            end
            if (got.accel_applied !== want.accel_applied) begin
                errors++;
                $display("%0t: accel_applied expected %0b actual %0b",
                         $time, want.accel_applied, got.accel_applied);
            end
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    angle_scoreboard sb;
    bit              calm;
    bit              long_hold_req;
    int unsigned     hold_count;
    int unsigned     settings_count;

    tilt_complementary_filter_unit #(
        .CORDIC_ITERATIONS(CORDIC_STEPS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic in_t sample(input logic signed [15:0] ax, ay, az, gx, gy);
        in_t d;
        d.acc_x  = ax;
        d.acc_y  = ay;
        d.acc_z  = az;
        d.gyro_x = gx;
        d.gyro_y = gy;
        return d;
    endfunction

    function automatic logic signed [15:0] rand_axis(input int unsigned span);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return 16'($urandom);
        if (pick < 8) return 16'($urandom_range(0, 2 * span)) - 16'(span);
        if (pick < 9) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        return '0;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap(input int unsigned long_max);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, long_max);
    endfunction

    task automatic push_sample(input in_t d);
        int unsigned gap;
        gap = pick_gap(80);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] val);
        @(negedge aclk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_write <= 1'b0;
    endtask

    // drop valid, drain, then reprogram while the block is idle
    task automatic load_settings(input logic [16:0] alpha, gain, lo, hi);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(negedge aclk);
        write_reg(REG_ALPHA_WEIGHT, alpha);
        write_reg(REG_GYRO_GAIN, gain);
        write_reg(REG_MAGNITUDE_LOW, lo);
        write_reg(REG_MAGNITUDE_HIGH, hi);
        settings_count++;
    endtask

    // result side: random stalls, plus the long hold-off on request
    initial begin : result_sink
        int unsigned stall_left;
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
                hold_count++;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap(120);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if (s_valid && s_ready) sb.note_input(s_data);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, sb.pending());
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        logic [16:0] alpha, gain, lo, hi;
        int unsigned r;
        sb             = new();
        calm           = 1'b0;
        long_hold_req  = 1'b0;
        hold_count     = 0;
        settings_count = 1;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // power-on settings: window edges, atan2 corner cases, quadrants
        push_sample(sample(0, 0, 0, 0, 0));
        push_sample(sample(0, 0, -20000, 100, -100));
        push_sample(sample(20000, 0, 0, -7, 7));
        push_sample(sample(0, 8192, 0, 1, 1));
        push_sample(sample(0, 8193, 0, 1, -1));
        push_sample(sample(10000, 10000, 12768, 0, 0));
        push_sample(sample(-10000, -10000, -12767, 3, 3));
        push_sample(sample(-5000, 5000, -15000, -3, 2));
        push_sample(sample(5000, -5000, 15000, 2, -3));
        push_sample(sample(32767, 32767, 32767, 32767, -32768));
        push_sample(sample(-32768, -32768, -32768, -32768, 32767));

        // full weight, largest gain, window up to full-scale magnitude: drive the angles into saturation
        load_settings(17'd65536, 17'd65535, 17'd0, 17'd98304);
        push_sample(sample(0, 0, 0, 32767, -32768));
        push_sample(sample(0, 0, 0, 32767, -32768));
        push_sample(sample(-32768, -32768, -32768, -32768, 32767));
        push_sample(sample(-32768, -32768, -32767, -32768, 32767));
        push_sample(sample(1, 0, 0, 0, 0));

        // weight above one is clamped
        load_settings(17'h1ffff, 17'd0, 17'd0, 17'h1ffff);
        push_sample(sample(100, -200, 300, 5, 5));
        push_sample(sample(-32768, 32767, -1, -1, 1));

        // empty window, zero weight; writes to unused indexes must be ignored
        load_settings(17'd0, 17'd1, 17'd50000, 17'd50000);
        write_reg(REG_OUT_OF_RANGE, 17'h1ffff);
        write_reg(REG_TOP_CODE, 17'd1);
        push_sample(sample(20000, 20000, 10001, 9, 9));
        push_sample(sample(0, 0, 0, -32768, 32767));

        load_settings(17'd6554, 17'd10, 17'd98304, 17'd0);
        push_sample(sample(1000, 1000, 1000, 50, -50));

        for (int p = 0; p < RAND_PHASES; p++) begin
            r = $urandom_range(0, 99);
            alpha = r < 70 ? 17'($urandom_range(0, 65536))
                  : r < 85 ? 17'd65536 : 17'($urandom_range(65537, 131071));
            gain  = $urandom_range(0, 3) != 0 ? 17'($urandom_range(0, 300))
                                              : 17'($urandom);
            r = $urandom_range(0, 99);
            if (r < 80) begin
                lo = 17'($urandom_range(0, 30000));
                hi = 17'($urandom_range(60000, 131071));
            end else begin
                lo = 17'($urandom);
                hi = 17'($urandom);
            end
            load_settings(alpha, gain, lo, hi);
            calm = (p == 1 || p == 3);
            // fill the block while the result side holds off
            if (p == 1) long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                push_sample(sample(rand_axis(300), rand_axis(300), rand_axis(300),
                                   rand_axis(500), rand_axis(500)));
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("Checked %0d samples (%0d with accelerometer blend) over %0d settings,",
                 sb.checked, sb.blended, settings_count);
        $display("with %0d long result hold-off(s) and %0d field errors.",
                 hold_count, sb.errors);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/tcf_pkg.sv
hw/rtl/tcf_cordic.sv
hw/rtl/tilt_complementary_filter_unit.sv
tb/sv/tb_tilt_complementary_filter_unit.sv
